/* rtl/vac_pkg.sv */
package vac_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 14;
    localparam int IN_FIELD_W = 12;
    localparam int COS_W      = 16;
    localparam int STAT_W     = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_NORMAL   = 2'd0,
        ST_COINCIDE = 2'd1,
        ST_ZERO_ARM = 2'd2
    } t_status;

endpackage

/* rtl/vac_dist.sv */
module vac_dist #(
    parameter int COORD_BITS = vac_pkg::COORD_BITS,
    parameter int DW         = 2 * COORD_BITS + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [COORD_BITS-1:0]   i_vx,
    input  logic [COORD_BITS-1:0]   i_vy,
    input  logic [COORD_BITS-1:0]   i_px,
    input  logic [COORD_BITS-1:0]   i_py,
    input  logic [COORD_BITS-1:0]   i_qx,
    input  logic [COORD_BITS-1:0]   i_qy,
    output logic                    o_valid,
    output logic [2*DW-1:0]         o_prod,
    output logic [DW:0]             o_mag,
    output logic                    o_neg,
    output vac_pkg::t_status        o_status
);

    localparam int SQW = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] n_d [0:5];
    logic [COORD_BITS-1:0] r_d [0:5];
    logic [SQW-1:0]        r_sq [0:5];
    logic [DW-1:0]         r_a, r_b, r_c;
    logic [2:0]            r_v;
    logic [DW:0]           n_bc;
    vac_pkg::t_status      n_status;

    function automatic logic [COORD_BITS-1:0] absdiff(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y
    );
        return (x > y) ? x - y : y - x;
    endfunction

    // order: a = |p-q|, b = |q-v|, c = |p-v|, x then y
    always_comb begin
        n_d[0] = absdiff(i_px, i_qx);
        n_d[1] = absdiff(i_py, i_qy);
        n_d[2] = absdiff(i_qx, i_vx);
        n_d[3] = absdiff(i_qy, i_vy);
        n_d[4] = absdiff(i_px, i_vx);
        n_d[5] = absdiff(i_py, i_vy);
    end

    always_comb begin
        n_bc = {1'b0, r_b} + {1'b0, r_c};
        if (r_a == '0) begin
            n_status = vac_pkg::ST_COINCIDE;
        end else if (r_b == '0 || r_c == '0) begin
            n_status = vac_pkg::ST_ZERO_ARM;
        end else begin
            n_status = vac_pkg::ST_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[1:0], i_valid};
            o_valid <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_d[k]  <= n_d[k];
                r_sq[k] <= r_d[k] * r_d[k];
            end
            r_a      <= DW'(r_sq[0]) + DW'(r_sq[1]);
            r_b      <= DW'(r_sq[2]) + DW'(r_sq[3]);
            r_c      <= DW'(r_sq[4]) + DW'(r_sq[5]);
            o_prod   <= r_b * r_c;
            o_neg    <= {1'b0, r_a} > n_bc;
            o_mag    <= ({1'b0, r_a} > n_bc) ? {1'b0, r_a} - n_bc : n_bc - {1'b0, r_a};
            o_status <= n_status;
        end
    end

endmodule

/* rtl/vac_sqrt.sv */
module vac_sqrt #(
    parameter int IW = 54,
    parameter int SW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IW-1:0]     i_rad,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [IW/2-1:0]   o_root,
    output logic [SW-1:0]     o_side
);

    localparam int RW = IW / 2;

    logic              r_v    [1:RW];
    logic [IW-1:0]     r_rem  [1:RW];
    logic [RW-1:0]     r_root [1:RW];
    logic [SW-1:0]     r_side [1:RW];

    // one root bit per stage, most significant first
    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int I = RW - 1 - k;
        logic              w_v;
        logic [IW-1:0]     w_rem;
        logic [RW-1:0]     w_root;
        logic [SW-1:0]     w_side;
        logic [IW:0]       w_trial;
        logic              w_take;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = i_rad;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k];
            assign w_rem  = r_rem[k];
            assign w_root = r_root[k];
            assign w_side = r_side[k];
        end

        assign w_trial = ((IW+1)'(w_root) << (I + 1)) | ((IW+1)'(1) << (2 * I));
        assign w_take  = {1'b0, w_rem} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_take ? IW'({1'b0, w_rem} - w_trial) : w_rem;
                r_root[k+1] <= w_take ? (w_root | (RW'(1) << I)) : w_root;
                r_side[k+1] <= w_side;
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule

/* rtl/vac_div.sv */
module vac_div #(
    parameter int NW        = 28,
    parameter int RW        = 27,
    parameter int FRAC_BITS = vac_pkg::FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [NW-1:0]             i_mag,
    input  logic [RW-1:0]             i_root,
    input  logic                      i_neg,
    input  vac_pkg::t_status          i_status,
    output logic                      o_valid,
    output logic [vac_pkg::COS_W-1:0] o_cosine,
    output vac_pkg::t_status          o_status
);

    localparam int QB  = FRAC_BITS + 2;
    localparam int XW  = NW + FRAC_BITS + 2;
    localparam int DVW = RW + 1;
    localparam int CW  = FRAC_BITS + 2;
    localparam int OW  = vac_pkg::COS_W;

    logic                  r_v0;
    logic [XW-1:0]         r_num0;
    logic [DVW-1:0]        r_den0;
    logic                  r_sat0, r_neg0;
    vac_pkg::t_status      r_st0;

    logic                  r_v    [1:QB];
    logic [XW-1:0]         r_num  [1:QB];
    logic [DVW-1:0]        r_den  [1:QB];
    logic [QB-1:0]         r_q    [1:QB];
    logic                  r_sat  [1:QB];
    logic                  r_neg  [1:QB];
    vac_pkg::t_status      r_st   [1:QB];

    logic [DVW-1:0]        w_den;
    logic [FRAC_BITS:0]    w_mag;
    logic [CW-1:0]         w_sgn;
    logic [OW-1:0]         w_cos;

    assign w_den = {i_root, 1'b0};

    // quotient at or above four is far past one, so only QB quotient bits are needed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num0 <= XW'(i_mag) << FRAC_BITS;
            r_den0 <= w_den;
            r_sat0 <= (NW + 2)'(i_mag) >= ((NW + 2)'(w_den) << 2);
            r_neg0 <= i_neg;
            r_st0  <= i_status;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int J = QB - 1 - k;
        logic              w_v;
        logic [XW-1:0]     w_num;
        logic [DVW-1:0]    w_dv;
        logic [QB-1:0]     w_q;
        logic              w_s, w_n;
        vac_pkg::t_status  w_st;
        logic [XW-1:0]     w_sub;
        logic              w_take;

        if (k == 0) begin : g_first
            assign w_v   = r_v0;
            assign w_num = r_num0;
            assign w_dv  = r_den0;
            assign w_q   = '0;
            assign w_s   = r_sat0;
            assign w_n   = r_neg0;
            assign w_st  = r_st0;
        end else begin : g_next
            assign w_v   = r_v[k];
            assign w_num = r_num[k];
            assign w_dv  = r_den[k];
            assign w_q   = r_q[k];
            assign w_s   = r_sat[k];
            assign w_n   = r_neg[k];
            assign w_st  = r_st[k];
        end

        assign w_sub  = XW'(w_dv) << J;
        assign w_take = w_num >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1] <= w_take ? w_num - w_sub : w_num;
                r_q[k+1]   <= w_take ? (w_q | (QB'(1) << J)) : w_q;
                r_den[k+1] <= w_dv;
                r_sat[k+1] <= w_s;
                r_neg[k+1] <= w_n;
                r_st[k+1]  <= w_st;
            end
        end
    end

    always_comb begin
        if (r_sat[QB] || r_q[QB] > (QB'(1) << FRAC_BITS)) begin
            w_mag = (FRAC_BITS+1)'(1) << FRAC_BITS;
        end else begin
            w_mag = r_q[QB][FRAC_BITS:0];
        end
        unique case (r_st[QB])
            vac_pkg::ST_COINCIDE: w_sgn = CW'(1) << FRAC_BITS;
            vac_pkg::ST_ZERO_ARM: w_sgn = '0;
            default:              w_sgn = r_neg[QB] ? -CW'(w_mag) : CW'(w_mag);
        endcase
    end

    if (CW >= OW) begin : g_trunc
        assign w_cos = w_sgn[OW-1:0];
    end else begin : g_sext
        assign w_cos = {{(OW - CW){w_sgn[CW-1]}}, w_sgn};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v0    <= i_valid;
            o_valid <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cosine <= w_cos;
            o_status <= r_st[QB];
        end
    end

endmodule

/* rtl/vertex_angle_cosine.sv */
// throughput: one transfer per cycle while the output is not stalled, each unit is a pipeline with a register per step
// the square root gives one root bit per stage, the divider one quotient bit per stage
// the whole pipe advances when the output register is empty or being taken
// synchronous active-low reset clears all valid bits; data registers are not reset
module vertex_angle_cosine #(
    parameter int COORD_BITS = vac_pkg::COORD_BITS,
    parameter int FRAC_BITS  = vac_pkg::FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vertex_x[11:0], vertex_y[23:12], first_x[35:24], first_y[47:36],
    // second_x[59:48], second_y[71:60]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cosine[15:0], signed fixed point
    output logic [15:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);

    localparam int FW = vac_pkg::IN_FIELD_W;
    // coordinate bits taken from each field, never more than the field holds
    localparam int CB = (COORD_BITS < FW) ? COORD_BITS : FW;
    localparam int DW = 2 * COORD_BITS + 1;   // squared distance width
    localparam int PW = 2 * DW;               // product of two squared distances
    localparam int RW = DW;                   // root width
    localparam int NW = DW + 1;               // |b + c - a| width
    localparam int SW = NW + 1 + vac_pkg::STAT_W;

    logic                    w_en;
    logic                    w_dv, w_neg, w_sv, w_s_neg;
    logic [PW-1:0]           w_prod;
    logic [NW-1:0]           w_mag, w_s_mag;
    logic [RW-1:0]           w_root;
    logic [SW-1:0]           w_side, w_s_side;
    vac_pkg::t_status        w_st, w_s_st;
    logic                    w_ov;
    logic [vac_pkg::COS_W-1:0] w_cos;
    vac_pkg::t_status        w_ost;

    // one stall for the whole pipe, freed whenever the output slot is open
    assign w_en          = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = w_en;

    // squared distances, special cases and the product b*c
    vac_dist #(.COORD_BITS(COORD_BITS), .DW(DW)) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s_axis_tvalid),
        .i_vx     (COORD_BITS'(s_axis_tdata[0*FW +: CB])),
        .i_vy     (COORD_BITS'(s_axis_tdata[1*FW +: CB])),
        .i_px     (COORD_BITS'(s_axis_tdata[2*FW +: CB])),
        .i_py     (COORD_BITS'(s_axis_tdata[3*FW +: CB])),
        .i_qx     (COORD_BITS'(s_axis_tdata[4*FW +: CB])),
        .i_qy     (COORD_BITS'(s_axis_tdata[5*FW +: CB])),
        .o_valid  (w_dv),
        .o_prod   (w_prod),
        .o_mag    (w_mag),
        .o_neg    (w_neg),
        .o_status (w_st)
    );

    // numerator magnitude, sign and status ride alongside the root
    assign w_side = {w_st, w_neg, w_mag};

    vac_sqrt #(.IW(PW), .SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv),
        .i_rad   (w_prod),
        .i_side  (w_side),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    assign w_s_mag = w_s_side[NW-1:0];
    assign w_s_neg = w_s_side[NW];
    assign w_s_st  = vac_pkg::t_status'(w_s_side[SW-1 -: vac_pkg::STAT_W]);

    // quotient, saturation and the final fixed-point code; last stage is the output register
    vac_div #(.NW(NW), .RW(RW), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_sv),
        .i_mag    (w_s_mag),
        .i_root   (w_root),
        .i_neg    (w_s_neg),
        .i_status (w_s_st),
        .o_valid  (w_ov),
        .o_cosine (w_cos),
        .o_status (w_ost)
    );

    assign m_axis_tvalid = w_ov;
    assign m_axis_tdata  = w_cos;
    assign m_axis_tuser  = w_ost;

endmodule

/* rtl/vac_checker.sv */
module vac_checker #(
    parameter int FRAC_BITS = vac_pkg::FRAC_BITS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    localparam logic [15:0] ONE_CODE = 16'(32'd1 << FRAC_BITS);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_zero_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == vac_pkg::ST_ZERO_ARM |-> m_axis_tdata == '0)
        else $error("zero-length arm with nonzero cosine");

    a_coincide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == vac_pkg::ST_COINCIDE |-> m_axis_tdata == ONE_CODE)
        else $error("coincident endpoints without cosine of one");

    // no input transfer while the result is stalled
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !(s_axis_tvalid && s_axis_tready))
        else $error("input taken while the result is stalled");

endmodule

bind vertex_angle_cosine vac_checker #(.FRAC_BITS(FRAC_BITS)) u_vac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* sim/tb.sv */
module tb;

    localparam int LATENCY   = 4 + (2*vac_pkg::COORD_BITS+1) + vac_pkg::FRAC_BITS + 4;
    localparam int N_RANDOM  = 440;
    localparam int WATCHDOG  = 20000;

    typedef struct {
        logic [15:0]      cosine;
        vac_pkg::t_status status;
    } t_angle_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int  n_errors = 0;
    int  idle_cycles = 0;
    bit  long_holdoff = 1'b0;

    always #6 i_clk = ~i_clk;

    vertex_angle_cosine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        n_errors++;
    endtask

    // floor square root, one bit per pass
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] rem, root, bit_w;
        rem = v;
        root = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > rem) bit_w >>= 2;
        while (bit_w != 0) begin
            if (rem >= root + bit_w) begin
                rem -= root + bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] dist_sq(input logic [63:0] ax, ay, bx, by);
        logic [63:0] dx, dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return dx*dx + dy*dy;
    endfunction

    function automatic t_angle_result predict_cosine(input logic [71:0] pts);
        logic [63:0] vx, vy, px, py, qx, qy, a, b, c, s, bc, mag, q, one;
        t_angle_result r;
        logic neg;
        vx = 64'(pts[11:0]);  vy = 64'(pts[23:12]);
        px = 64'(pts[35:24]); py = 64'(pts[47:36]);
        qx = 64'(pts[59:48]); qy = 64'(pts[71:60]);
        one = 64'd1 << vac_pkg::FRAC_BITS;
        a = dist_sq(px, py, qx, qy);
        b = dist_sq(qx, qy, vx, vy);
        c = dist_sq(px, py, vx, vy);
        if (a == 0) begin
            r.cosine = one[15:0];
            r.status = vac_pkg::ST_COINCIDE;
        end else if (b == 0 || c == 0) begin
            r.cosine = '0;
            r.status = vac_pkg::ST_ZERO_ARM;
        end else begin
            s = floor_root(b * c);
            bc = b + c;
            neg = a > bc;
            mag = neg ? a - bc : bc - a;
            q = (mag << vac_pkg::FRAC_BITS) / (64'd2 * s);
            if (q > one) q = one;
            q = neg ? -q : q;
            r.cosine = q[15:0];
            r.status = vac_pkg::ST_NORMAL;
        end
        return r;
    endfunction

    class angle_scoreboard;
        t_angle_result pending[$];

        function void note_points(input logic [71:0] pts);
            pending.push_back(predict_cosine(pts));
        endfunction

        task check_result(input logic [15:0] cosine, input logic [1:0] status);
            t_angle_result want;
            if (pending.size() == 0) begin
                report("unexpected result", 32'({status, cosine}), 32'd0);
                return;
            end
            want = pending.pop_front();
            if (cosine !== want.cosine) report("cosine", 32'(cosine), 32'(want.cosine));
            if (status !== want.status) report("status", 32'(status), 32'(want.status));
        endtask
    endclass

    angle_scoreboard sb = new();

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    function automatic logic [71:0] pack_points(input logic [11:0] vx, vy, px, py, qx, qy);
        return {qy, qx, py, px, vy, vx};
    endfunction

    // offer one point triple and hold it until the transfer
    task automatic send_points(input logic [71:0] pts);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pts;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_with_gap(input logic [71:0] pts, input bit allow_gap);
        int g;
        send_points(pts);
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic [11:0] near(input logic [11:0] base, input int spread);
        int v;
        v = int'(base) + $signed($urandom_range(0, 2*spread)) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    // scoreboard side: note inputs, check outputs at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_points(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout");
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            if (long_holdoff) begin
                m_axis_tready <= 1'b0;
                repeat (3*LATENCY) @(posedge i_clk);
                long_holdoff = 1'b0;
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [11:0] vx, vy, px, py, qx, qy;
        int kind, waited;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: coincident endpoints, zero arms, collinear, extremes
        send_with_gap(pack_points(0, 0, 0, 0, 0, 0), 1'b1);
        send_with_gap(pack_points(12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff), 1'b1);
        send_with_gap(pack_points(5, 5, 100, 200, 100, 200), 1'b1);
        send_with_gap(pack_points(5, 5, 5, 5, 100, 7), 1'b1);
        send_with_gap(pack_points(100, 9, 3000, 40, 100, 9), 1'b1);
        send_with_gap(pack_points(2048, 2048, 0, 2048, 4095, 2048), 1'b1);
        send_with_gap(pack_points(2048, 2048, 4095, 2048, 3000, 2048), 1'b1);
        send_with_gap(pack_points(0, 0, 4095, 0, 0, 4095), 1'b1);
        send_with_gap(pack_points(0, 0, 4095, 4095, 4095, 4095 - 1), 1'b0);
        send_with_gap(pack_points(0, 0, 4095, 4095, 1, 1), 1'b0);
        send_with_gap(pack_points(4095, 0, 0, 4095, 0, 4094), 1'b0);
        send_with_gap(pack_points(1, 1, 2, 1, 1, 2), 1'b0);
        send_with_gap(pack_points(1, 1, 2, 2, 0, 0), 1'b0);
        send_with_gap(pack_points(4095, 4095, 0, 0, 0, 1), 1'b0);
        send_with_gap(pack_points(0, 4095, 4095, 0, 4095, 4095), 1'b0);
        send_with_gap(pack_points(12'haaa, 12'h555, 12'h555, 12'haaa, 12'hfff, 12'h000), 1'b1);

        // fill the pipe against a stalled receiver
        long_holdoff = 1'b1;
        repeat (2*LATENCY) begin
            send_with_gap(pack_points(12'($urandom), 12'($urandom), 12'($urandom),
                                      12'($urandom), 12'($urandom), 12'($urandom)), 1'b0);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 9);
            vx = 12'($urandom); vy = 12'($urandom);
            px = 12'($urandom); py = 12'($urandom);
            qx = 12'($urandom); qy = 12'($urandom);
            case (kind)
                0: begin qx = px; qy = py; end
                1: begin px = vx; py = vy; end
                2: begin qx = vx; qy = vy; end
                3: begin // small shapes near the vertex: rounding overshoot territory
                    px = near(vx, 3); py = near(vy, 3);
                    qx = near(vx, 3); qy = near(vy, 3);
                end
                4: begin // collinear through the vertex
                    py = vy; qy = vy;
                end
                default: ;
            endcase
            send_with_gap(pack_points(vx, vy, px, py, qx, qy), n % 64 < 48);
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 100*WATCHDOG) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2*LATENCY) @(posedge i_clk);
        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            if (sb.pending.size() != 0) $display("%0d results never arrived", sb.pending.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
